>>> src/bhta_pkg.sv
// shared types and constants for the bucketed hash table with aging
package bhta_pkg;

  localparam int BHT_BUCKETS = 4096;
  localparam int BHT_WAYS    = 3;
  localparam int Q_DEPTH     = 2;
  localparam int CFG_W       = 13;
  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  localparam logic [4:0] AGE_RESET  = 5'd1;
  localparam logic [1:0] BOUND_EXACT = 2'd3;
  localparam logic [9:0] DEPTH_MARGIN = 10'd5;

  typedef enum logic [1:0] {
    REQ_PROBE = 2'd0,
    REQ_STORE = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_AGE   = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [63:0]        key;
    logic [15:0]        move;
    logic signed [15:0] score;
    logic signed [15:0] eval;
    logic [1:0]         bound;
    logic [7:0]         depth;
    logic               pv;
    logic               was_pv;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic [15:0]        out_move;
    logic signed [15:0] out_score;
    logic signed [15:0] out_eval;
    logic [7:0]         out_depth;
    logic [1:0]         out_bound;
    logic               out_was_pv;
  } out_item_t;

  // 80-bit entry: tag, move, score, eval, depth, flag byte (age, pv, bound)
  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] mv;
    logic [15:0] sc;
    logic [15:0] ev;
    logic [7:0]  dep;
    logic [4:0]  age;
    logic        pvf;
    logic [1:0]  bnd;
  } entry_t;

endpackage

>>> src/bucketed_hash_table_with_aging.sv
// top level of the bucketed hash table with aging
//
//  channel   ports                      handshake
//  request   start, busy, in_data       taken when start && !busy
//  result    out_valid, out_data        one-cycle strobe, cannot be held off
//  config    cfg_we, cfg_wdata          written when cfg_we
//
// the front end takes one request per cycle while busy is low and registers the index
// multiply; the back end handles each request as a bucket read, then update and result,
// on the single read port of the way memories, and takes the next only after the result
// with nothing ahead, a request passes the front stage, queue, bucket read and result register
// clear holds the back end for a zeroing sweep over all BUCKETS buckets (4096 by default)
// after its result, and the same sweep runs after reset with busy held high
// busy rises when the queue and the front stage are full
module bucketed_hash_table_with_aging import bhta_pkg::*; #(
  parameter int BUCKETS = BHT_BUCKETS,
  parameter int WAYS    = BHT_WAYS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int QW = $bits(in_item_t) + BW;

  logic [CFG_W-1:0] bucket_cnt_r;
  logic             front_ready, init_busy, accept;
  logic             push, pop, q_full, q_empty;
  in_item_t         push_item, q_item;
  logic [BW-1:0]    push_bucket, q_bucket;
  logic [QW-1:0]    q_rdata;

  // way memories
  logic              rd_en;
  logic [BW-1:0]     rd_addr, wr_addr;
  logic [WAYS-1:0]   wr_en;
  entry_t            rd_data [WAYS];
  entry_t            wr_data [WAYS];

  // no request while the zeroing sweep after reset is still running or the front stage cannot pass its request on
  assign busy   = init_busy || !front_ready;
  assign accept = start && !busy;

  // bucket count register; the user must write it only while idle, the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) bucket_cnt_r <= CFG_RESET;
    else if (cfg_we) bucket_cnt_r <= cfg_wdata;
  end

  bhta_front #(.BUCKETS(BUCKETS)) u_front (
    .clk, .rst_n, .accept, .item(in_data), .bucket_cnt(bucket_cnt_r),
    .q_full, .ready(front_ready), .push, .push_item, .push_bucket
  );

  bhta_queue #(.W(QW)) u_queue (
    .clk, .rst_n, .push, .wdata({push_bucket, push_item}), .pop,
    .rdata(q_rdata), .full(q_full), .empty(q_empty)
  );

  assign q_item   = in_item_t'(q_rdata[$bits(in_item_t)-1:0]);
  assign q_bucket = q_rdata[QW-1 -: BW];

  bhta_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
    .clk, .rst_n, .q_empty, .q_item, .q_bucket, .q_pop(pop),
    .rd_en, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data,
    .init_busy, .out_valid, .out_data
  );

  // one memory per way, all ways of a bucket read together
  for (genvar w = 0; w < WAYS; w++) begin : g_way
    logic [$bits(entry_t)-1:0] rd_raw;
    bhta_ram #(.W($bits(entry_t)), .D(BUCKETS)) u_ram (
      .clk, .we(wr_en[w]), .wa(wr_addr), .wd(wr_data[w]),
      .re(rd_en), .ra(rd_addr), .rd(rd_raw)
    );
    assign rd_data[w] = entry_t'(rd_raw);
  end

endmodule

>>> src/bhta_ram.sv
// generic single-write, single-read ram with registered read data
module bhta_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [W-1:0]  wd,
  input  logic          re,
  input  logic [AW-1:0] ra,
  output logic [W-1:0]  rd
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd <= mem[ra];
  end

endmodule

>>> src/bhta_front.sv
// front end: accepts requests and computes the bucket index in two steps
module bhta_front import bhta_pkg::*; #(
  parameter int BUCKETS = BHT_BUCKETS,
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
  localparam int NW = $clog2(BUCKETS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  in_item_t         item,
  input  logic [CFG_W-1:0] bucket_cnt,
  input  logic             q_full,
  output logic             ready,
  output logic             push,
  output in_item_t         push_item,
  output logic [BW-1:0]    push_bucket
);

  localparam int PW = 32 + NW;

  logic [NW-1:0] n_clamped;
  logic [PW-1:0] lo_p_nxt, hi_p_nxt, lo_p_r, hi_p_r;
  logic [PW:0]   sum;
  logic          s1_v_r;
  in_item_t      item_r;

  always_comb begin
    if ({{NW{1'b0}}, bucket_cnt} > (NW+CFG_W)'(BUCKETS)) n_clamped = NW'(BUCKETS);
    else n_clamped = NW'(bucket_cnt);
  end

  assign lo_p_nxt = PW'(item.key[31:0]) * PW'(n_clamped);
  assign hi_p_nxt = PW'(item.key[63:32]) * PW'(n_clamped);
  assign sum      = {1'b0, hi_p_r} + (PW+1)'(lo_p_r[PW-1:32]);

  assign push        = s1_v_r && !q_full;
  assign ready       = !s1_v_r || !q_full;
  assign push_item   = item_r;
  assign push_bucket = sum[32 +: BW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (push) begin
      s1_v_r <= 1'b0;
    end
    if (accept) begin
      item_r <= item;
      lo_p_r <= lo_p_nxt;
      hi_p_r <= hi_p_nxt;
    end
  end

endmodule

>>> src/bhta_queue.sv
// short register queue between front and back end
module bhta_queue import bhta_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  localparam int PTW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW  = $clog2(Q_DEPTH + 1);

  logic [W-1:0]   slot_r [Q_DEPTH];
  logic [PTW-1:0] wp_r, rp_r;
  logic [CW-1:0]  cnt_r;

  assign full  = (cnt_r == CW'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PTW'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PTW'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
    if (push) slot_r[wp_r] <= wdata;
  end

endmodule

>>> src/bhta_back.sv
// back end: bucket read, probe and replacement, clearing sweep, table age
module bhta_back import bhta_pkg::*; #(
  parameter int BUCKETS = BHT_BUCKETS,
  parameter int WAYS    = BHT_WAYS,
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
  localparam int IW = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  in_item_t      q_item,
  input  logic [BW-1:0] q_bucket,
  output logic          q_pop,
  output logic          rd_en,
  output logic [BW-1:0] rd_addr,
  input  entry_t        rd_data [WAYS],
  output logic [WAYS-1:0] wr_en,
  output logic [BW-1:0] wr_addr,
  output entry_t        wr_data [WAYS],
  output logic          init_busy,
  output logic          out_valid,
  output out_item_t     out_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_WB, ST_CLR} state_t;

  state_t        state_r, state_nxt;
  in_item_t      item_r, item_nxt;
  logic [BW-1:0] bkt_r, bkt_nxt, cnt_r, cnt_nxt;
  logic [4:0]    age_r, age_nxt;
  logic          init_r, init_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic signed [9:0] val [WAYS];
  logic [IW-1:0]     t_idx, p_idx;
  logic              found, p_hit, same, rewrite;
  logic [15:0]       tag;
  logic [4:0]        age_gap;
  entry_t            old_e, new_e;

  assign init_busy = init_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign tag       = item_r.key[15:0];

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    bkt_nxt       = bkt_r;
    cnt_nxt       = cnt_r;
    age_nxt       = age_r;
    init_nxt      = init_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = q_bucket;
    wr_en         = '0;
    wr_addr       = bkt_r;
    for (int i = 0; i < WAYS; i++) begin
      wr_data[i] = '0;
      age_gap    = age_r - rd_data[i].age;
      val[i]     = $signed({2'b00, rd_data[i].dep}) - $signed({3'b000, age_gap, 2'b00});
    end
    // replacement choice: matching way, else least value, earliest on ties
    t_idx = '0;
    found = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      if (!found) begin
        if (rd_data[i].tag == tag) begin
          t_idx = IW'(i);
          found = 1'b1;
        end else if (val[t_idx] > val[i]) begin
          t_idx = IW'(i);
        end
      end
    end
    p_idx = IW'(WAYS - 1);
    p_hit = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      if (!p_hit && rd_data[i].tag == tag) begin
        p_idx = IW'(i);
        p_hit = 1'b1;
      end
    end
    old_e   = rd_data[t_idx];
    same    = (old_e.tag == tag);
    rewrite = (item_r.bound == BOUND_EXACT) || !same || (old_e.age != age_r) ||
              ({2'b00, item_r.depth} + DEPTH_MARGIN + {8'd0, item_r.pv, 1'b0} >
               {2'b00, old_e.dep});
    new_e   = old_e;
    if (item_r.move != '0 || !same) new_e.mv = item_r.move;
    if (rewrite) begin
      new_e.tag = tag;
      new_e.sc  = item_r.score;
      new_e.ev  = item_r.eval;
      new_e.dep = item_r.depth;
      new_e.age = age_r;
      new_e.pvf = item_r.was_pv;
      new_e.bnd = item_r.bound;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          rd_en     = 1'b1;
          item_nxt  = q_item;
          bkt_nxt   = q_bucket;
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        unique case (req_t'(item_r.req_type))
          REQ_PROBE: begin
            out_data_nxt.hit        = p_hit;
            out_data_nxt.out_move   = rd_data[p_idx].mv;
            out_data_nxt.out_score  = rd_data[p_idx].sc;
            out_data_nxt.out_eval   = rd_data[p_idx].ev;
            out_data_nxt.out_depth  = rd_data[p_idx].dep;
            out_data_nxt.out_bound  = rd_data[p_idx].bnd;
            out_data_nxt.out_was_pv = rd_data[p_idx].pvf;
          end
          REQ_STORE: begin
            wr_en[t_idx]   = 1'b1;
            wr_data[t_idx] = new_e;
          end
          REQ_CLEAR: begin
            age_nxt   = AGE_RESET;
            cnt_nxt   = '0;
            state_nxt = ST_CLR;
          end
          REQ_AGE: age_nxt = age_r + 5'd1;
        endcase
      end
      ST_CLR: begin
        wr_en   = '1;
        wr_addr = cnt_r;
        if (cnt_r == BW'(BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
          init_nxt  = 1'b0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      cnt_r       <= '0;
      age_r       <= AGE_RESET;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      age_r       <= age_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    bkt_r      <= bkt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> src/bhta_checker.sv
// port-level checks for the bucketed hash table, bound to the top level
module bhta_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // the zeroing sweep holds off requests right after reset
  a_busy_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> busy)
    else $error("busy low right after reset");

  a_no_result_from_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset cycle");

  // the back end takes no new transaction until it has returned its result
  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results in consecutive cycles");

  // handshake outputs are always driven out of reset
  a_known_handshake: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({busy, out_valid}))
    else $error("busy or result strobe unknown");

endmodule

bind bucketed_hash_table_with_aging bhta_checker u_chk (.*);

>>> bench/tb_bucketed_hash_table_with_aging.sv
// testbench for the bucketed hash table with aging
`timescale 1ns / 100ps

module tb_bucketed_hash_table_with_aging;
  import bhta_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_item_t         in_data;
  logic             out_valid;
  out_item_t        out_data;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  bucketed_hash_table_with_aging u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow table and state kept by the predictor
  entry_t           shadow_tbl [BHT_BUCKETS][BHT_WAYS];
  logic [4:0]       shadow_age;
  logic [CFG_W-1:0] shadow_buckets;

  out_item_t        pending_results [$];
  int               mismatch_cnt;
  int               failures;
  bit               idle_enable;
  logic [63:0]      key_pool [16];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit: long enough that even an all-clear run of zeroing sweeps finishes
  initial begin
    #100ms;
    $display("status: fail");
    $finish;
  end

  // bucket index: high 64 bits of key * min(buckets_in_use, BUCKETS)
  function automatic int bucket_index(logic [63:0] key);
    logic [127:0] prod;
    logic [63:0]  n;
    n = (shadow_buckets > BHT_BUCKETS) ? 64'(BHT_BUCKETS) : 64'(shadow_buckets);
    prod = {64'd0, key} * {64'd0, n};
    return int'(prod[127:64]);
  endfunction

  function automatic int entry_worth(entry_t e);
    logic [4:0] age_gap;
    age_gap = shadow_age - e.age;
    return int'(e.dep) - 4 * int'(age_gap);
  endfunction

  function automatic void wipe_table();
    foreach (shadow_tbl[b, w]) shadow_tbl[b][w] = '0;
    shadow_age = AGE_RESET;
  endfunction

  // predicted result of one accepted transaction; updates the shadow state
  function automatic out_item_t lookup_or_update(in_item_t it);
    out_item_t  res;
    int         b;
    int         tgt;
    bit         same;
    logic [15:0] tag;
    res = '0;
    tag = it.key[15:0];
    b = bucket_index(it.key);
    case (req_t'(it.req_type))
      REQ_PROBE: begin
        tgt = BHT_WAYS - 1;
        for (int w = 0; w < BHT_WAYS; w++) begin
          if (shadow_tbl[b][w].tag == tag) begin
            tgt = w;
            res.hit = 1'b1;
            break;
          end
        end
        res.out_move   = shadow_tbl[b][tgt].mv;
        res.out_score  = shadow_tbl[b][tgt].sc;
        res.out_eval   = shadow_tbl[b][tgt].ev;
        res.out_depth  = shadow_tbl[b][tgt].dep;
        res.out_bound  = shadow_tbl[b][tgt].bnd;
        res.out_was_pv = shadow_tbl[b][tgt].pvf;
      end
      REQ_STORE: begin
        // matching way, else least worth with the earliest way winning ties
        tgt = 0;
        for (int w = 0; w < BHT_WAYS; w++) begin
          if (shadow_tbl[b][w].tag == tag) begin
            tgt = w;
            break;
          end
          if (entry_worth(shadow_tbl[b][tgt]) > entry_worth(shadow_tbl[b][w])) tgt = w;
        end
        same = (shadow_tbl[b][tgt].tag == tag);
        if (it.move != 16'd0 || !same) shadow_tbl[b][tgt].mv = it.move;
        if (it.bound == BOUND_EXACT || !same ||
            (int'(it.depth) + 5 + 2 * int'(it.pv) > int'(shadow_tbl[b][tgt].dep)) ||
            shadow_tbl[b][tgt].age != shadow_age) begin
          shadow_tbl[b][tgt].tag = tag;
          shadow_tbl[b][tgt].bnd = it.bound;
          shadow_tbl[b][tgt].pvf = it.was_pv;
          shadow_tbl[b][tgt].age = shadow_age;
          shadow_tbl[b][tgt].sc  = it.score;
          shadow_tbl[b][tgt].ev  = it.eval;
          shadow_tbl[b][tgt].dep = it.depth;
        end
      end
      REQ_CLEAR: wipe_table();
      default:   shadow_age = shadow_age + 5'd1;
    endcase
    return res;
  endfunction

  // result checker: every strobe must match the oldest pending prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        failures++;
        if (mismatch_cnt < 10) $display("unexpected result %p", out_data);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.hit !== want.hit || out_data.out_move !== want.out_move ||
            out_data.out_score !== want.out_score || out_data.out_eval !== want.out_eval ||
            out_data.out_depth !== want.out_depth || out_data.out_bound !== want.out_bound ||
            out_data.out_was_pv !== want.out_was_pv) begin
          failures++;
          if (mismatch_cnt < 10) $display("mismatch: expected %p actual %p", want, out_data);
          mismatch_cnt++;
        end
      end
    end
  end

  // send one transaction; start stays high unless an idle gap follows
  task automatic send_req(in_item_t it);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    pending_results.push_back(lookup_or_update(it));
    if (idle_enable && $urandom_range(99) < 24) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // stop sending and wait until every predicted result has arrived
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // a clear sweep may outlast its result, so let it finish before writing
  task automatic cfg_write(logic [CFG_W-1:0] v);
    drain();
    repeat (BHT_BUCKETS + 64) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    shadow_buckets = v;
  endtask

  function automatic in_item_t make_req(req_t r, logic [63:0] key, logic [15:0] mv,
                                        logic [7:0] dep, logic [1:0] bnd, logic pv);
    in_item_t it;
    it.req_type = r;
    it.key      = key;
    it.move     = mv;
    it.score    = 16'($urandom);
    it.eval     = 16'($urandom);
    it.bound    = bnd;
    it.depth    = dep;
    it.pv       = pv;
    it.was_pv   = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t random_req();
    in_item_t   it;
    int         roll;
    req_t       r;
    logic [63:0] key;
    roll = $urandom_range(999);
    r = (roll < 450) ? REQ_PROBE : (roll < 910) ? REQ_STORE :
        (roll < 990) ? REQ_AGE : REQ_CLEAR;
    // mostly pooled keys so probes find earlier stores and buckets fill
    if ($urandom_range(9) < 7) key = key_pool[$urandom_range(15)];
    else key = {$urandom, $urandom};
    it = make_req(r, key, ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom),
                  8'($urandom), 2'($urandom), 1'($urandom));
    return it;
  endfunction

  // empty table: tag zero hits, other tags miss onto the last way
  task automatic test_reset_probe();
    send_req(make_req(REQ_PROBE, 64'h0, 16'h0, 8'h0, 2'd0, 1'b0));
    send_req(make_req(REQ_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 8'h0, 2'd0, 1'b0));
  endtask

  // store, hit, keep move on zero, exact overwrite, shallow store ignored
  task automatic test_store_probe();
    in_item_t it;
    it = make_req(REQ_STORE, 64'h8000_0000_0000_1234, 16'hFFFF, 8'd255, 2'd2, 1'b1);
    it.score = 16'sh7FFF;
    it.eval  = -16'sd32768;
    send_req(it);
    send_req(make_req(REQ_PROBE, 64'h8000_0000_0000_1234, 16'h0, 8'h0, 2'd0, 1'b0));
    send_req(make_req(REQ_STORE, 64'h8000_0000_0000_1234, 16'h0, 8'd0, 2'd1, 1'b0));
    send_req(make_req(REQ_STORE, 64'h8000_0000_0000_1234, 16'h0, 8'd10, BOUND_EXACT, 1'b0));
    send_req(make_req(REQ_PROBE, 64'h8000_0000_0000_1234, 16'h0, 8'h0, 2'd0, 1'b0));
    send_req(make_req(REQ_STORE, 64'h8000_0000_0000_1234, 16'h5A5A, 8'd250, 2'd0, 1'b1));
    send_req(make_req(REQ_PROBE, 64'h8000_0000_0000_1234, 16'h0, 8'h0, 2'd0, 1'b0));
  endtask

  // four tags into one bucket forces replacement, then aging ranks entries
  task automatic test_replace_age();
    for (int i = 1; i <= 4; i++)
      send_req(make_req(REQ_STORE, 64'h0000_0000_0000_0100 + 64'(i), 16'(i),
                        8'(i * 3), 2'd0, 1'b0));
    send_req(make_req(REQ_AGE, 64'h0, 16'h0, 8'h0, 2'd0, 1'b0));
    send_req(make_req(REQ_STORE, 64'h0000_0000_0000_0102, 16'h0, 8'd0, 2'd0, 1'b0));
    send_req(make_req(REQ_STORE, 64'h0000_0000_0000_0777, 16'h7, 8'd1, 2'd0, 1'b0));
    for (int i = 1; i <= 4; i++)
      send_req(make_req(REQ_PROBE, 64'h0000_0000_0000_0100 + 64'(i), 16'h0, 8'h0, 2'd0, 1'b0));
    // age wraps modulo 32
    for (int i = 0; i < 32; i++)
      send_req(make_req(REQ_AGE, 64'(i), 16'h0, 8'h0, 2'd0, 1'b0));
    send_req(make_req(REQ_CLEAR, 64'h0, 16'h0, 8'h0, 2'd0, 1'b0));
    send_req(make_req(REQ_PROBE, 64'h0000_0000_0000_0101, 16'h0, 8'h0, 2'd0, 1'b0));
  endtask

  // zero, one, out-of-range and full bucket counts
  task automatic test_cfg_extremes();
    logic [CFG_W-1:0] vals [4] = '{13'd0, 13'd1, 13'h1FFF, 13'd4096};
    foreach (vals[v]) begin
      cfg_write(vals[v]);
      for (int i = 0; i < 6; i++) send_req(random_req());
    end
  endtask

  task automatic test_random();
    logic [CFG_W-1:0] vals [5];
    vals = '{13'($urandom_range(1, 8)), 13'd4096, 13'($urandom_range(1, 8191)),
             13'($urandom_range(1, 64)), 13'd4096};
    foreach (vals[v]) begin
      cfg_write(vals[v]);
      foreach (key_pool[k]) key_pool[k] = {$urandom, $urandom};
      key_pool[0][15:0] = 16'h0000;
      for (int i = 0; i < 85; i++) begin
        idle_enable = !(v == 2);  // one phase runs back to back
        send_req(random_req());
      end
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    mismatch_cnt = 0;
    failures  = 0;
    idle_enable = 1'b1;
    shadow_buckets = CFG_RESET;
    wipe_table();
    foreach (key_pool[k]) key_pool[k] = {$urandom, $urandom};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_probe();
    test_store_probe();
    test_replace_age();
    test_cfg_extremes();
    test_random();

    drain();
    repeat (BHT_BUCKETS + 64) @(posedge clk);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
